// ===== rtl/u16u8_pkg.sv =====
// ============================================================================
// u16u8_pkg
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
// ============================================================================
package u16u8_pkg;

  localparam int unsigned UNIT_W    = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CP_W      = 21;
  localparam int unsigned FIFO_DEPTH = 2;

  // Upper six bits of a code unit that mark the surrogate ranges.
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
  localparam logic [CP_W-1:0] MAX_1BYTE = 21'h00007f;
  localparam logic [CP_W-1:0] MAX_2BYTE = 21'h0007ff;
  localparam logic [CP_W-1:0] MAX_3BYTE = 21'h00ffff;

  // One job for the back end: the bytes of one result run.
  typedef struct packed {
    logic [3:0][BYTE_W-1:0] bytes;
    logic [1:0]             last_idx;
    logic                   eot;
    logic                   err;
  } job_t;

endpackage

// ===== rtl/utf16_to_utf8_transcoder_core.sv =====
// ============================================================================
// utf16_to_utf8_transcoder_core
// Converts a stream of UTF-16 code units into UTF-8 bytes.
// ============================================================================
// Channel  | Dir | tdata              | tlast        | tuser
// in_      | in  | [15:0] code_unit   | end_of_text  | -
// out_     | out | [7:0]  out_byte    | last_of_run  | [0] text_done, [1] error
//
// The byte sequencer sends one byte per cycle unless the output stalls, so a
// unit yields one to four bytes: one below 0x80, two below 0x800, three for the
// rest of the BMP, four for a surrogate pair; a held high surrogate or a dropped
// unit yields none. Reset is synchronous and clears the pairing state, the job
// queue and the output stage. The front end stalls only when the job queue is
// full; the output register lets a new unit enter while a byte waits to be taken.
// ============================================================================
module utf16_to_utf8_transcoder_core #(
  parameter int unsigned FIFO_DEPTH = u16u8_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] code_unit
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,
  output logic [1:0]  out_tuser   // [0] text_done, [1] error
);

  logic            acc;
  logic            push;
  logic            full;
  logic            pop;
  logic            job_valid;
  u16u8_pkg::job_t front_job;
  u16u8_pkg::job_t head_job;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  u16u8_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .unit  (in_tdata),
    .eot   (in_tlast),
    .push  (push),
    .job   (front_job)
  );

  u16u8_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (front_job),
    .full      (full),
    .pop       (pop),
    .not_empty (job_valid),
    .head      (head_job)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job_in     (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/u16u8_front.sv =====
// ============================================================================
// u16u8_front
// Accepts code units, tracks surrogate pairing and builds byte jobs.
// ============================================================================
module u16u8_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           acc,
  input  logic [u16u8_pkg::UNIT_W-1:0]   unit,
  input  logic                           eot,
  output logic                           push,
  output u16u8_pkg::job_t                job
);

  logic [9:0] held_r, held_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       dropping_r, dropping_nxt;

  logic                          is_high, is_low;
  logic [u16u8_pkg::CP_W-1:0]    cp_bmp, cp_supp;
  u16u8_pkg::job_t               job_bmp, job_supp, job_err;

  function automatic u16u8_pkg::job_t encode(input logic [u16u8_pkg::CP_W-1:0] cp,
                                              input logic e);
    u16u8_pkg::job_t j;
    j       = '0;
    j.eot   = e;
    j.err   = 1'b0;
    if (cp <= u16u8_pkg::MAX_1BYTE) begin
      j.bytes[0] = {1'b0, cp[6:0]};
      j.last_idx = 2'd0;
    end else if (cp <= u16u8_pkg::MAX_2BYTE) begin
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
      j.last_idx = 2'd1;
    end else if (cp <= u16u8_pkg::MAX_3BYTE) begin
      j.bytes[0] = {4'b1110, cp[15:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
      j.last_idx = 2'd2;
    end else begin
      j.bytes[0] = {5'b11110, cp[20:18]};
      j.bytes[1] = {2'b10, cp[17:12]};
      j.bytes[2] = {2'b10, cp[11:6]};
      j.bytes[3] = {2'b10, cp[5:0]};
      j.last_idx = 2'd3;
    end
    return j;
  endfunction

  assign is_high = (unit[15:10] == u16u8_pkg::HIGH_SURR_TAG);
  assign is_low  = (unit[15:10] == u16u8_pkg::LOW_SURR_TAG);
  assign cp_bmp  = {5'b0, unit};
  assign cp_supp = u16u8_pkg::SUPP_BASE + {1'b0, held_r, unit[9:0]};

  always_comb begin
    job_bmp  = encode(cp_bmp, eot);
    job_supp = encode(cp_supp, eot);
    job_err          = '0;
    job_err.last_idx = 2'd0;
    job_err.eot      = 1'b1;
    job_err.err      = 1'b1;
  end

  always_comb begin
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    dropping_nxt   = dropping_r;
    push           = 1'b0;
    job            = job_bmp;
    if (acc) begin
      if (dropping_r) begin
        if (eot) begin
          dropping_nxt = 1'b0;
        end
      end else if (held_valid_r) begin
        held_valid_nxt = 1'b0;
        held_nxt       = '0;
        push           = 1'b1;
        if (is_low) begin
          job = job_supp;
        end else begin
          job          = job_err;
          dropping_nxt = !eot;
        end
      end else if (is_high) begin
        if (eot) begin
          push = 1'b1;
          job  = job_err;
        end else begin
          held_nxt       = unit[9:0];
          held_valid_nxt = 1'b1;
        end
      end else begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      held_valid_r <= 1'b0;
      dropping_r   <= 1'b0;
    end else begin
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      dropping_r   <= dropping_nxt;
    end
  end

endmodule

// ===== rtl/u16u8_fifo.sv =====
// ============================================================================
// u16u8_fifo
// Short job queue between the front end and the byte sequencer.
// ============================================================================
module u16u8_fifo #(
  parameter int unsigned DEPTH = u16u8_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u16u8_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output u16u8_pkg::job_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  u16u8_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/u16u8_back.sv =====
// ============================================================================
// u16u8_back
// Byte sequencer: sends the bytes of each job, one per cycle while the output is
// not stalled, through a registered output stage.
// ============================================================================
module u16u8_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  u16u8_pkg::job_t               job_in,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [u16u8_pkg::BYTE_W-1:0]  out_tdata,
  output logic                          out_tlast,
  output logic [1:0]                    out_tuser
);

  u16u8_pkg::job_t cur_r, cur_nxt;
  logic            cur_valid_r, cur_valid_nxt;
  logic [1:0]      idx_r, idx_nxt;

  logic                          ovalid_r, ovalid_nxt;
  logic [u16u8_pkg::BYTE_W-1:0]  obyte_r, obyte_nxt;
  logic                          olast_r, olast_nxt;
  logic                          odone_r, odone_nxt;
  logic                          oerr_r, oerr_nxt;

  logic advance, cur_last, load;

  assign advance  = !ovalid_r || out_tready;
  assign cur_last = (idx_r == cur_r.last_idx);
  assign load     = !cur_valid_r || (advance && cur_last);
  assign pop      = load && job_valid;

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      cur_valid_nxt = job_valid;
      cur_nxt       = job_in;
      idx_nxt       = '0;
    end else if (advance) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    odone_nxt  = odone_r;
    oerr_nxt   = oerr_r;
    if (advance) begin
      ovalid_nxt = cur_valid_r;
      obyte_nxt  = cur_r.bytes[idx_r];
      olast_nxt  = cur_last;
      odone_nxt  = cur_last && cur_r.eot;
      oerr_nxt   = cur_r.err;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
    oerr_r  <= oerr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      ovalid_r    <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      ovalid_r    <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = {oerr_r, odone_r};

endmodule

// ===== rtl/u16u8_checker.sv =====
// ============================================================================
// u16u8_checker
// Port-level checks of the transcoder, bound to the top level.
// ============================================================================
module u16u8_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  // A waiting input transaction keeps its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tlast))
    else $error("input payload changed while waiting");

  // A stalled output transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("output payload changed while stalled");

  // An error result is a single zero byte that ends the text.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 8'h00 && out_tlast && out_tuser[0])
    else $error("malformed error result");

  // The end of a text is always the end of a run.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("text_done without last_of_run");

  // Reset empties the output stage and frees the input.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output or input not idle after reset");

endmodule

bind utf16_to_utf8_transcoder_core u16u8_checker u_u16u8_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
